[hdl/positional_list_insert_delete_macros.svh]
// Assertion macros shared by the RTL. Each one checks on the rising edge of clk
// and is disabled while rst_n is low.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

`ifndef SYNTHESIS
`define PLI_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("positional list assertion failed");
`define PLI_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("positional list forbidden condition seen");
`else
`define PLI_ASSERT(name, prop)
`define PLI_NEVER(name, expr)
`endif

`endif

[hdl/pli_pkg.sv]
package pli_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [DATA_W-1:0] READ_INVALID = '1;

    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } pli_ctrl_t;

endpackage

[hdl/pli_cell.sv]
module pli_cell
    import pli_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 6
)
(
    input  logic              clk,
    input  pli_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] hit_data
);

    localparam int W = (IW > POS_W) ? IW : POS_W;

    logic [W-1:0]      my_idx;
    logic [W-1:0]      pos_x;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    assign my_idx = W'(IDX);
    assign pos_x  = W'(ctrl.pos);

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.ins_en)
        begin
            priority if (my_idx > pos_x)
            begin
                data_next = left;
            end
            else if (my_idx == pos_x)
            begin
                data_next = ctrl.value;
            end
            else
            begin
                data_next = data_reg;
            end
        end
        else if (ctrl.del_en && (my_idx >= pos_x))
        begin
            data_next = right;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (my_idx == pos_x) ? data_reg : '0;

endmodule

[hdl/positional_list_insert_delete.sv]
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells, one
// value per cell. A command (insert, delete or read at a position) is taken on any
// cycle in which start is high; busy never rises, so a command may be issued every
// cycle. All cells shift toward the back or the front in parallel on the same edge,
// and a read selects the addressed cell. The result
// (status, read_value, entry_count) appears on the cycle after the command, marked
// by done for exactly one cycle; the receiver cannot stall it and must take it then.
`include "positional_list_insert_delete_macros.svh"

module positional_list_insert_delete
    import pli_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]         entry_count
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;
    logic [CNT_W-1:0]  entry_count_reg;

    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cnt_x;
    logic              take;
    pli_ctrl_t         ctrl;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_hit  [CAPACITY];
    logic [DATA_W-1:0] rd_or;

    assign take  = start & ~busy;
    assign busy  = 1'b0;
    assign pos_x = CMPW'(position);
    assign cnt_x = CMPW'(count_reg);

    always_comb
    begin
        status_next     = ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        ctrl.ins_en     = 1'b0;
        ctrl.del_en     = 1'b0;
        ctrl.pos        = position;
        ctrl.value      = value;
        unique case (command)
            CMD_INSERT:
            begin
                priority if (pos_x > cnt_x)
                begin
                    status_next = ST_BADPOS;
                end
                else if (count_reg == CNT_CAP)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.ins_en = take;
                    count_next  = count_reg + 1'b1;
                end
            end
            CMD_DELETE:
            begin
                priority if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_x >= cnt_x)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    ctrl.del_en = take;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_READ:
            begin
                if (pos_x >= cnt_x)
                begin
                    status_next     = ST_BADPOS;
                    read_value_next = READ_INVALID;
                end
                else
                begin
                    read_value_next = rd_or;
                end
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        pli_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .left     (left_data),
            .right    (right_data),
            .data     (cell_data[i]),
            .hit_data (cell_hit[i])
        );
    end

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | cell_hit[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= take;
            if (take)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= CNT_W'(count_next);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

    `PLI_NEVER(a_count_in_range, count_reg > CNT_CAP)
    `PLI_ASSERT(a_done_follows_start, start |=> done)
    `PLI_ASSERT(a_full_only_at_capacity, (done && status == ST_FULL) |-> (count_reg == CNT_CAP))
    `PLI_ASSERT(a_empty_only_at_zero, (done && status == ST_EMPTY) |-> (count_reg == '0))
    `PLI_ASSERT(a_insert_grows, (start && ctrl.ins_en) |=> (count_reg == $past(count_reg) + 1'b1))

endmodule
